@@ design/mfb_pkg.sv @@
// Shared constants, codes and types for the one-bit-per-pixel framebuffer blitter.
package mfb_pkg;

    localparam int FB_BYTES        = 1024;
    localparam int MAX_WIDTH_BYTES = 32;

    localparam int ADDR_W  = $clog2(FB_BYTES);
    localparam int WIDTH_W = $clog2(MAX_WIDTH_BYTES + 1);
    localparam int ROWS_W  = 8;
    localparam int PROD_W  = ROWS_W + WIDTH_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CNT_W   = ADDR_W + 1;

    localparam int CFG_W_WIDTH  = 6;
    localparam int CFG_DATA_W   = 8;

    typedef enum logic [1:0] {
        OP_BLIT  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic {
        CFG_WIDTH_BYTES = 1'b0,
        CFG_HEIGHT_ROWS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ACC0,
        ST_ACC1,
        ST_ACC2,
        ST_FILL,
        ST_DONE
    } state_t;

    localparam logic [7:0] FILL_ONES  = 8'hFF;
    localparam logic [7:0] FILL_ZEROS = 8'h00;
    localparam logic [7:0] PIXEL_MSB  = 8'h80;

endpackage

@@ design/mono_framebuffer_bit_blit.sv @@
// Top level: framebuffer memory with read-modify-write sequencer for blit, pixel, fill and read.
// Sequence: accept, an address state (ST_CALC), then read/modify/write in ST_ACC0 and ST_ACC1
// (plus ST_ACC2 when a blit straddles two bytes), then ST_DONE loads the result register once the output is free.
// Fill writes one byte per cycle over width*height bytes (at most FB_BYTES).
// One item is worked at a time; the single read/write memory port pair sets the pace.
// Reset (rst_n, asynchronous) sets width 16 bytes, height 64 rows; memory is undefined until written.
module mono_framebuffer_bit_blit
    import mfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             operation,
    input  logic signed [10:0]     pos_x,
    input  logic signed [9:0]      pos_y,
    input  logic [4:0]             byte_index,
    input  logic [7:0]             source_byte,
    input  logic                   invert,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             read_data,
    output logic                   landed,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W_WIDTH-1:0] width_reg;
    logic [ROWS_W-1:0]      height_reg;
    logic [WIDTH_W-1:0]     weff;

    // item registers
    op_t                op_reg;
    logic signed [10:0] px_reg;
    logic signed [9:0]  py_reg;
    logic [4:0]         bi_reg;
    logic [7:0]         src_reg;
    logic               inv_reg;

    // address stage results
    logic [ADDR_W-1:0]  addr0_reg, addr0_next;
    logic [ADDR_W-1:0]  addr1_reg, addr1_next;
    logic               in0_reg, in0_next;
    logic               in1_reg, in1_next;
    logic               need1_reg, need1_next;
    logic [7:0]         bits0_reg, bits0_next;
    logic [7:0]         bits1_reg, bits1_next;
    logic [CNT_W-1:0]   fill_n_reg, fill_n_next;
    logic               landed_reg, landed_next;
    logic [7:0]         rd_reg, rd_next;
    logic [ADDR_W-1:0]  fill_addr_reg, fill_addr_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg, out_data_next;
    logic               out_landed_reg, out_landed_next;

    // memory port
    logic [7:0]         frame_mem [FB_BYTES];
    logic               mem_re, mem_we;
    logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata_reg;

    // address arithmetic
    logic signed [11:0] x_pix;
    logic signed [11:0] col0, col1;
    logic [2:0]         shift;
    logic               row_in;
    logic               col0_in, col1_in;
    logic [PROD_W-1:0]  row_base;
    logic [SUM_W-1:0]   sum0, sum1;
    logic [PROD_W-1:0]  area;
    logic               in_accept;
    logic               out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign landed    = out_landed_reg;

    assign weff = (WIDTH_W'(width_reg) > WIDTH_W'(MAX_WIDTH_BYTES))
                ? WIDTH_W'(MAX_WIDTH_BYTES) : WIDTH_W'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W_WIDTH'(16);
            height_reg <= ROWS_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WIDTH_BYTES: width_reg  <= cfg_data[CFG_W_WIDTH-1:0];
                CFG_HEIGHT_ROWS: height_reg <= cfg_data[ROWS_W-1:0];
                default:         width_reg  <= width_reg;
            endcase
        end
    end

    // Hold the item for the whole sequence.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= op_t'(operation);
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            bi_reg  <= byte_index;
            src_reg <= source_byte;
            inv_reg <= invert;
        end
    end

    // Byte columns and target addresses, worked out in the address cycle.
    always_comb
    begin
        x_pix = {px_reg[10], px_reg} + $signed({4'b0000, bi_reg, 3'b000});
        case (op_reg)
            OP_BLIT:
            begin
                col0  = x_pix >>> 3;
                shift = x_pix[2:0];
            end
            OP_PIXEL:
            begin
                col0  = {{4{px_reg[10]}}, px_reg[10:3]};
                shift = px_reg[2:0];
            end
            default:
            begin
                col0  = {px_reg[10], px_reg};
                shift = px_reg[2:0];
            end
        endcase
        col1 = col0 + 12'sd1;

        row_in  = !py_reg[9] && (py_reg[8:0] < {1'b0, height_reg});
        col0_in = !col0[11] && (col0[10:0] < 11'(weff));
        col1_in = !col1[11] && (col1[10:0] < 11'(weff));

        row_base = PROD_W'(py_reg[ROWS_W-1:0]) * PROD_W'(weff);
        sum0     = SUM_W'(row_base) + SUM_W'(col0[WIDTH_W-1:0]);
        sum1     = SUM_W'(row_base) + SUM_W'(col1[WIDTH_W-1:0]);
        area     = PROD_W'(weff) * PROD_W'(height_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_CALC;
            ST_CALC:
            begin
                if (op_reg == OP_FILL)
                    state_next = (area != '0) ? ST_FILL : ST_DONE;
                else
                    state_next = ST_ACC0;
            end
            ST_ACC0: state_next = ST_ACC1;
            ST_ACC1: state_next = need1_reg ? ST_ACC2 : ST_DONE;
            ST_ACC2: state_next = ST_DONE;
            ST_FILL:
            begin
                if (CNT_W'(fill_addr_reg) + CNT_W'(1) == fill_n_reg)
                    state_next = ST_DONE;
            end
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        addr0_next      = addr0_reg;
        addr1_next      = addr1_reg;
        in0_next        = in0_reg;
        in1_next        = in1_reg;
        need1_next      = need1_reg;
        bits0_next      = bits0_reg;
        bits1_next      = bits1_reg;
        fill_n_next     = fill_n_reg;
        landed_next     = landed_reg;
        rd_next         = rd_reg;
        fill_addr_next  = fill_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        out_landed_next = out_landed_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_raddr       = addr0_reg;
        mem_waddr       = addr0_reg;
        mem_wdata       = FILL_ZEROS;

        case (state_reg)
            ST_CALC:
            begin
                addr0_next = sum0[ADDR_W-1:0];
                addr1_next = sum1[ADDR_W-1:0];
                in0_next   = row_in && col0_in && ({1'b0, sum0} < (SUM_W + 1)'(FB_BYTES));
                in1_next   = row_in && col1_in && ({1'b0, sum1} < (SUM_W + 1)'(FB_BYTES));
                need1_next = (op_reg == OP_BLIT) && (shift != 3'd0);
                if (op_reg == OP_PIXEL)
                    bits0_next = PIXEL_MSB >> shift;
                else
                    bits0_next = src_reg >> shift;
                bits1_next = 8'(src_reg << (4'd8 - {1'b0, shift}));
                if ({1'b0, area} > (PROD_W + 1)'(FB_BYTES))
                    fill_n_next = CNT_W'(FB_BYTES);
                else
                    fill_n_next = CNT_W'(area);
                rd_next = FILL_ZEROS;
                if (op_reg == OP_FILL)
                    landed_next = (area != '0);
                else if (op_reg == OP_BLIT)
                    landed_next = (in0_next || (need1_next && in1_next));
                else
                    landed_next = in0_next;
            end
            ST_ACC0:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr0_reg;
            end
            ST_ACC1:
            begin
                // Read the second byte while the first one is written back.
                mem_re    = need1_reg;
                mem_raddr = addr1_reg;
                mem_we    = in0_reg && (op_reg != OP_READ);
                mem_waddr = addr0_reg;
                mem_wdata = inv_reg ? (mem_rdata_reg & ~bits0_reg)
                                    : (mem_rdata_reg | bits0_reg);
                if (op_reg == OP_READ && in0_reg)
                    rd_next = mem_rdata_reg;
            end
            ST_ACC2:
            begin
                mem_we    = in1_reg;
                mem_waddr = addr1_reg;
                mem_wdata = inv_reg ? (mem_rdata_reg & ~bits1_reg)
                                    : (mem_rdata_reg | bits1_reg);
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = inv_reg ? FILL_ONES : FILL_ZEROS;
                if (CNT_W'(fill_addr_reg) + CNT_W'(1) == fill_n_reg)
                    fill_addr_next = '0;
                else
                    fill_addr_next = fill_addr_reg + ADDR_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rd_reg;
                    out_landed_next = landed_reg;
                end
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr0_reg      <= addr0_next;
        addr1_reg      <= addr1_next;
        in0_reg        <= in0_next;
        in1_reg        <= in1_next;
        need1_reg      <= need1_next;
        bits0_reg      <= bits0_next;
        bits1_reg      <= bits1_next;
        fill_n_reg     <= fill_n_next;
        landed_reg     <= landed_next;
        rd_reg         <= rd_next;
        out_data_reg   <= out_data_next;
        out_landed_reg <= out_landed_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= frame_mem[mem_raddr];
    end

endmodule

@@ tb/sv/fb_blit_checker.sv @@
// Checker for the framebuffer blitter: mirrors the frame memory and compares each result beat.
`timescale 1ns / 100ps
module fb_blit_checker
    import mfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic signed [10:0]    pos_x,
    input  logic signed [9:0]     pos_y,
    input  logic [4:0]            byte_index,
    input  logic [7:0]            source_byte,
    input  logic                  invert,

    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            read_data,
    input  logic                  landed,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    fail_count,
    output int                    awaiting
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       landed;
    } fb_reply_t;

    logic [7:0] frame_copy [FB_BYTES];
    logic [5:0] width_reg;
    logic [7:0] height_reg;
    fb_reply_t  replies_owed [$];
    int         mismatches;

    function automatic int used_width();
        return (width_reg > MAX_WIDTH_BYTES) ? MAX_WIDTH_BYTES : int'(width_reg);
    endfunction

    // Address of a byte column in a row, or -1 when it lies off the display or past memory.
    function automatic int byte_addr(input int col, input int row);
        int w;
        int addr;
        w = used_width();
        if (row < 0 || row >= int'(height_reg))
            return -1;
        if (col < 0 || col >= w)
            return -1;
        addr = row * w + col;
        if (addr >= FB_BYTES)
            return -1;
        return addr;
    endfunction

    function automatic bit merge_bits(input int col, input int row, input logic [7:0] bits,
                                      input logic clear);
        int addr;
        addr = byte_addr(col, row);
        if (addr < 0)
            return 1'b0;
        if (clear)
            frame_copy[addr] = frame_copy[addr] & ~bits;
        else
            frame_copy[addr] = frame_copy[addr] | bits;
        return 1'b1;
    endfunction

    function automatic fb_reply_t draw_op(input op_t op, input logic signed [10:0] px,
                                          input logic signed [9:0] py, input logic [4:0] bi,
                                          input logic [7:0] src, input logic inv);
        fb_reply_t r;
        int        x;
        int        s;
        int        col;
        int        n;
        int        addr;
        r = '0;
        case (op)
            OP_BLIT:
            begin
                x   = int'(px) + 8 * int'(bi);
                s   = x & 7;
                col = (x - s) / 8;
                if (merge_bits(col, py, src >> s, inv))
                    r.landed = 1'b1;
                // spill the low bits into the next column when the byte straddles two
                if (s != 0 && merge_bits(col + 1, py, 8'(src << (8 - s)), inv))
                    r.landed = 1'b1;
            end
            OP_PIXEL:
            begin
                if (int'(px) >= 0 && int'(px) < used_width() * 8)
                    r.landed = merge_bits(int'(px) / 8, py, PIXEL_MSB >> px[2:0], inv);
            end
            OP_FILL:
            begin
                n = used_width() * int'(height_reg);
                if (n > FB_BYTES)
                    n = FB_BYTES;
                for (int i = 0; i < n; i++)
                    frame_copy[i] = inv ? FILL_ONES : FILL_ZEROS;
                r.landed = (n > 0);
            end
            OP_READ:
            begin
                addr = byte_addr(px, py);
                if (addr >= 0)
                begin
                    r.read_data = frame_copy[addr];
                    r.landed    = 1'b1;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fb_reply_t want;
        fb_reply_t seen;
        if (!rst_n)
        begin
            width_reg  = 6'd16;
            height_reg = 8'd64;
            mismatches = 0;
            replies_owed.delete();
            fail_count <= 0;
            awaiting   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.read_data = read_data;
                seen.landed    = landed;
                if (replies_owed.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing owed: read_data %h landed %b",
                                 $realtime, read_data, landed);
                end
                else
                begin
                    want = replies_owed.pop_front();
                    if (seen.read_data !== want.read_data || seen.landed !== want.landed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: read_data exp %h got %h, landed exp %b got %b",
                                     $realtime, want.read_data, seen.read_data,
                                     want.landed, seen.landed);
                    end
                end
            end
            if (in_valid && !in_stall)
                replies_owed.push_back(draw_op(op_t'(operation), pos_x, pos_y, byte_index,
                                               source_byte, invert));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WIDTH_BYTES)
                    width_reg = cfg_data[5:0];
                else
                    height_reg = cfg_data;
            end
            awaiting   <= replies_owed.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top: clock, reset, stimulus and verdict for the framebuffer blitter.
`timescale 1ns / 100ps
module tb_top;
    import mfb_pkg::*;

    localparam int TIMEOUT_NS = 2_000_000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [1:0]            operation   = OP_READ;
    logic signed [10:0]    pos_x       = '0;
    logic signed [9:0]     pos_y       = '0;
    logic [4:0]            byte_index  = '0;
    logic [7:0]            source_byte = '0;
    logic                  invert      = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [7:0]            read_data;
    logic                  landed;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index   = CFG_WIDTH_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int fail_count;
    int awaiting;
    int gap_pct   = 10;
    int stall_pct = 80;
    int cur_w     = 16;
    int cur_h     = 64;

    mono_framebuffer_bit_blit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .byte_index  (byte_index),
        .source_byte (source_byte),
        .invert      (invert),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .landed      (landed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    fb_blit_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .byte_index  (byte_index),
        .source_byte (source_byte),
        .invert      (invert),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .landed      (landed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .awaiting    (awaiting)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic send_item(input op_t op, input logic signed [10:0] px,
                             input logic signed [9:0] py, input logic [4:0] bi,
                             input logic [7:0] src, input logic inv);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        pos_x       <= px;
        pos_y       <= py;
        byte_index  <= bi;
        source_byte <= src;
        invert      <= inv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold the sender until every owed result beat has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // Mostly coordinates around the display so that blits and reads hit real bytes.
    task automatic random_item();
        int   pick;
        int   px;
        int   py;
        int   bi;
        op_t  op;
        pick = $urandom_range(99);
        op   = (pick < 40) ? OP_BLIT : (pick < 65) ? OP_PIXEL : (pick < 97) ? OP_READ : OP_FILL;
        bi   = $urandom_range(31);
        if ($urandom_range(99) < 85)
        begin
            py = int'($urandom_range(cur_h + 2)) - 1;
            case (op)
                OP_BLIT:  px = int'($urandom_range(cur_w * 8 + 12)) - 10 - 8 * bi;
                OP_PIXEL: px = int'($urandom_range(cur_w * 8 + 4)) - 2;
                default:  px = int'($urandom_range(cur_w + 1)) - 1;
            endcase
        end
        else
        begin
            px = int'($urandom_range(2047)) - 1024;
            py = int'($urandom_range(1023)) - 512;
        end
        send_item(op, 11'(px), 10'(py), 5'(bi), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
    endtask

    task automatic run_phase(input logic [7:0] w_data, input logic [7:0] h_data,
                             input int items, input int gap, input int stall);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WIDTH_BYTES;
        cfg_data  <= w_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // keep valid up across the second write beat
        cfg_index <= CFG_HEIGHT_ROWS;
        cfg_data  <= h_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_w     = (w_data[5:0] > MAX_WIDTH_BYTES) ? MAX_WIDTH_BYTES : int'(w_data[5:0]);
        cur_h     = int'(h_data);
        gap_pct   = gap;
        stall_pct <= stall;
        // fill first so that no byte inside the new layout is read before it is written
        send_item(OP_FILL, 0, 0, 0, 8'h00, 1'($urandom_range(1)));
        for (int k = 0; k < items; k++)
        begin
            if (k == items / 2 && items >= 80)
                wait_idle();
            random_item();
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default 16 x 64 layout
        send_item(OP_FILL,  0,     0,    0,  8'h00, 1'b1);
        send_item(OP_READ,  0,     0,    0,  8'h00, 1'b0);
        send_item(OP_BLIT,  0,     0,    0,  8'hA5, 1'b1);
        send_item(OP_BLIT,  3,     1,    0,  8'hFF, 1'b1);
        send_item(OP_BLIT,  -3,    2,    0,  8'hFF, 1'b1);
        send_item(OP_BLIT,  125,   3,    0,  8'hFF, 1'b1);
        send_item(OP_BLIT,  -248,  63,   31, 8'h0F, 1'b1);
        send_item(OP_BLIT,  -1024, 4,    31, 8'hFF, 1'b1);
        send_item(OP_BLIT,  1023,  5,    0,  8'hFF, 1'b1);
        send_item(OP_BLIT,  8,     -512, 0,  8'hFF, 1'b1);
        send_item(OP_BLIT,  8,     511,  0,  8'hFF, 1'b1);
        send_item(OP_PIXEL, 127,   63,   0,  8'h00, 1'b1);
        send_item(OP_PIXEL, -1,    0,    0,  8'h00, 1'b1);
        send_item(OP_PIXEL, 128,   0,    0,  8'h00, 1'b1);
        send_item(OP_PIXEL, 0,     64,   0,  8'h00, 1'b1);
        send_item(OP_READ,  0,     1,    0,  8'h00, 1'b0);
        send_item(OP_READ,  15,    63,   0,  8'h00, 1'b0);
        send_item(OP_FILL,  0,     0,    0,  8'h00, 1'b0);
        send_item(OP_BLIT,  5,     10,   0,  8'hFF, 1'b0);
        send_item(OP_PIXEL, 0,     0,    0,  8'h00, 1'b0);
        send_item(OP_READ,  1,     10,   0,  8'h00, 1'b0);
        send_item(OP_READ,  0,     0,    0,  8'h00, 1'b0);
        send_item(OP_READ,  16,    0,    0,  8'h00, 1'b0);
        send_item(OP_READ,  -1024, -512, 0,  8'h00, 1'b0);
        send_item(OP_READ,  1023,  511,  0,  8'h00, 1'b0);

        run_phase(8'd1,   8'd1,   40, 10, 80);
        run_phase(8'd32,  8'd128, 90, 10, 80);
        run_phase(8'd63,  8'd255, 80, 10, 80);
        run_phase(8'd0,   8'd20,  25, 80, 10);
        run_phase(8'd7,   8'd0,   25, 80, 10);
        run_phase(8'hC8,  8'd200, 90, 80, 10);
        run_phase(8'd13,  8'd37,  90, 0,  0);
        run_phase(8'd32,  8'd32,  90, 0,  0);
        run_phase(8'd16,  8'd64,  90, 0,  0);

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && awaiting == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
